// ===== rtl/core/fefll_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fefll_pkg : shared types and constants of the fsk edge frequency locked loop
// widths, divider request, sine quarter-wave table and saturation helper
// ----------------------------------------------------------------------------
package fefll_pkg;

    // sample and register widths
    localparam int SAMPLE_W   = 16;
    localparam int ROLLOFF_W  = 15;
    localparam int WINDOW_W   = 13;
    localparam int SUM_W      = 28;
    localparam int PROD_W     = 2 * ROLLOFF_W;
    localparam int DIV_W      = WINDOW_W + 2;
    localparam int CNT_W      = $clog2(SUM_W);

    // window limit
    localparam int MAX_WINDOW = 4096;

    // sine table geometry
    localparam int SINE_DEPTH = 256;
    localparam int SINE_AW    = $clog2(SINE_DEPTH);
    localparam int SINE_IW    = SINE_AW + 1;
    localparam int PHASE_W    = SINE_AW + 2;
    localparam int SINE_W     = 15;

    // register indexes
    localparam logic [1:0] REG_ROLLOFF_WIDTH = 2'd0;
    localparam logic [1:0] REG_ROLLOFF_RECIP = 2'd1;
    localparam logic [1:0] REG_UPDATE_SAMPLES = 2'd2;

    typedef logic [SINE_W-1:0] sine_tab_t [0:SINE_DEPTH];

    // request to the divider
    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  numerator;
        logic [DIV_W-1:0]  divisor;
    } div_req_t;

    // quarter-wave sine in q1.14, taylor series in q2.30, built at elaboration
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t   tab;
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] term;
        longint      sum;
        for (int i = 0; i <= SINE_DEPTH; i++) begin
            a    = (64'd1686629713 * 64'(i)) / SINE_DEPTH;
            a2   = (a * a) >> 30;
            term = a;
            sum  = longint'(a);
            for (int n = 1; n <= 12; n++) begin
                term = ((term * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            sum = (sum + 32768) >>> 16;
            if (sum > 16384) begin
                sum = 16384;
            end
            tab[i] = SINE_W'(sum);
        end
        return tab;
    endfunction

    // clamp a 29-bit signed value to 16 bits
    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [28:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 29'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -29'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/fefll_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fefll_divider : restoring radix-2 divider
// one quotient bit per cycle, sum-width steps, done pulses once at the end
// ----------------------------------------------------------------------------
module fefll_divider (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  fefll_pkg::div_req_t          div_req,
    output logic                         div_done,
    output logic [fefll_pkg::SUM_W-1:0]  quotient
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [fefll_pkg::CNT_W-1:0]   cnt_reg;
    logic [fefll_pkg::SUM_W-1:0]   num_reg;
    logic [fefll_pkg::DIV_W-1:0]   den_reg;
    logic [fefll_pkg::DIV_W-1:0]   rem_reg;

    logic [fefll_pkg::DIV_W:0]     rem_shift;
    logic                          fits;

    // partial remainder stays below the divisor, one extra bit after the shift
    always_comb begin
        rem_shift = {rem_reg, num_reg[fefll_pkg::SUM_W-1]};
        fits      = rem_shift >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (div_req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == fefll_pkg::CNT_W'(fefll_pkg::SUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (div_req.start) begin
            num_reg <= div_req.numerator;
            den_reg <= div_req.divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[fefll_pkg::SUM_W-2:0], fits};
            if (fits) begin
                rem_reg <= fefll_pkg::DIV_W'(rem_shift - {1'b0, den_reg});
            end else begin
                rem_reg <= rem_shift[fefll_pkg::DIV_W-1:0];
            end
        end
    end

    assign div_done = done_reg;
    assign quotient = num_reg;

endmodule
`default_nettype wire

// ===== rtl/core/fsk_edge_frequency_locked_loop_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsk_edge_frequency_locked_loop_unit : frequency locked loop on fsk edges
// subtracts the offset estimate, averages a sine error taken from samples
// lying just outside the outer symbol levels, and moves the offset each window
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake           | word contents
//  ---------+-----+---------------------+-------------------------------------
//  s_       | in  | s_tvalid / s_tready | freq_sample
//  m_       | out | m_tvalid / m_tready | corrected_sample, offset_updated,
//           |     |                     | offset_value
//  cfg_wr_  | in  | cfg_wr_en           | rolloff_width, rolloff_reciprocal,
//           |     |                     | update_samples
//
//  a word outside the bands passes the band test, accumulate and done states
//  and goes into the output register once that is free, and the input is
//  ready again from that load; a word in a band also passes multiply and lookup
//  a word that closes a window adds divider load, quotient bits at one per
//  cycle, the done pulse and applying the offset step
//  s_tready is high only in idle; a finished word waits in the output
//  register while the next input word is already taken
//  synchronous active-low reset clears the offset, sum, count and registers
//  to their defaults; the sine table is constant and needs no fill
//
module fsk_edge_frequency_locked_loop_unit (
    input  wire         aclk,
    input  wire         aresetn,

    // input channel
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,      // [15:0] freq_sample

    // result channel
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,      // [15:0] corrected_sample, [16] offset_updated,
                                      // [32:17] offset_value, [39:33] zero

    // configuration writes
    input  wire         cfg_wr_en,
    input  wire  [1:0]  cfg_wr_index,
    input  wire  [14:0] cfg_wr_data
);

    // sequencer codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BAND  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_LOOK  = 4'd3;
    localparam logic [3:0] S_ACC   = 4'd4;
    localparam logic [3:0] S_DLOAD = 4'd5;
    localparam logic [3:0] S_DWAIT = 4'd6;
    localparam logic [3:0] S_APPLY = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    localparam int SW = fefll_pkg::SAMPLE_W;
    localparam int RW = fefll_pkg::ROLLOFF_W;
    localparam int WW = fefll_pkg::WINDOW_W;
    localparam int UW = fefll_pkg::SUM_W;
    localparam int PW = fefll_pkg::PROD_W;

    // phase step = round(|d| * recip * 2 * depth / 2^24)
    localparam int KSHIFT = 23 - fefll_pkg::SINE_AW;

    localparam logic signed [18:0] LEVEL_W = 19'sd12288;
    localparam logic [WW-1:0] WIN_MAX = WW'(fefll_pkg::MAX_WINDOW);
    localparam logic [PW-1:0] K_ROUND = PW'(1) << (KSHIFT - 1);
    localparam logic [fefll_pkg::SINE_IW-1:0] DEPTH_IDX =
        fefll_pkg::SINE_IW'(fefll_pkg::SINE_DEPTH);

    localparam fefll_pkg::sine_tab_t SINE_TAB = fefll_pkg::build_sine_tab();

    // configuration
    logic [RW-1:0]             width_reg;
    logic [RW-1:0]             recip_reg;
    logic [WW-1:0]             samples_reg;

    // loop state
    logic signed [SW-1:0]      off_reg;
    logic signed [UW-1:0]      sum_reg;
    logic [WW-1:0]             count_reg;

    // sequencer and working registers
    logic [3:0]                state_reg, state_next;
    logic signed [SW-1:0]      x_reg;
    logic signed [SW-1:0]      corr_reg;
    logic                      in_band_reg;
    logic                      d_neg_reg;
    logic [RW-1:0]             dmag_reg;
    logic [PW-1:0]             prod_reg;
    logic [fefll_pkg::SINE_W-1:0] sine_reg;
    logic                      sneg_reg;
    logic                      upd_reg;
    logic                      sum_neg_reg;

    // output register
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [39:0]               m_tdata_reg;

    // combinational datapath
    logic signed [18:0]        x_w, off_w, r_w, lo_w, hi_w;
    logic                      in_lo, in_hi;
    logic [PW-1:0]             k_sum;
    logic [fefll_pkg::PHASE_W-1:0] phase;
    logic [1:0]                quad;
    logic [fefll_pkg::SINE_AW-1:0] frac;
    logic [fefll_pkg::SINE_IW-1:0] tab_idx;
    logic signed [UW:0]        sum_w;
    logic signed [SW-1:0]      sine_v;
    logic signed [UW-1:0]      sum_sat;
    logic [WW-1:0]             count_new;
    logic [WW-1:0]             window;
    logic [UW-1:0]             sum_mag;
    logic signed [28:0]        off_sum;
    logic                      load_out;

    fefll_pkg::div_req_t       div_req;
    logic                      div_done;
    logic [UW-1:0]             quotient;

    // ---------------------------------------------------------------- config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= RW'(6554);
            recip_reg   <= RW'(2560);
            samples_reg <= WW'(256);
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                fefll_pkg::REG_ROLLOFF_WIDTH:  width_reg   <= cfg_wr_data;
                fefll_pkg::REG_ROLLOFF_RECIP:  recip_reg   <= cfg_wr_data;
                fefll_pkg::REG_UPDATE_SAMPLES: samples_reg <= WW'(cfg_wr_data);
                default: ;
            endcase
        end
    end

    // window clamped to one .. max window
    always_comb begin
        if (samples_reg == '0) begin
            window = WW'(1);
        end else if (samples_reg > WIN_MAX) begin
            window = WIN_MAX;
        end else begin
            window = samples_reg;
        end
    end

    // ----------------------------------------------------- band test, 19 bit
    always_comb begin
        x_w   = 19'(x_reg);
        off_w = 19'(off_reg);
        r_w   = 19'(width_reg);
        lo_w  = off_w - LEVEL_W;
        hi_w  = off_w + LEVEL_W;
        in_lo = (x_w < lo_w) && (x_w > lo_w - r_w);
        in_hi = (x_w > hi_w) && (x_w < hi_w + r_w);
    end

    // ----------------------------------------------- phase and table address
    always_comb begin
        k_sum   = prod_reg + K_ROUND;
        phase   = k_sum[KSHIFT +: fefll_pkg::PHASE_W];
        quad    = phase[fefll_pkg::PHASE_W-1 -: 2];
        frac    = phase[fefll_pkg::SINE_AW-1:0];
        // odd quadrants run the table backwards
        tab_idx = quad[0] ? (DEPTH_IDX - fefll_pkg::SINE_IW'(frac))
                          : fefll_pkg::SINE_IW'(frac);
    end

    // ------------------------------------------------------- accumulate step
    always_comb begin
        sine_v    = sneg_reg ? -SW'(sine_reg) : SW'(sine_reg);
        sum_w     = (UW+1)'(sum_reg) + (UW+1)'(sine_v);
        if (sum_w > (UW+1)'(signed'({1'b0, {(UW-1){1'b1}}}))) begin
            sum_sat = {1'b0, {(UW-1){1'b1}}};
        end else if (sum_w < (UW+1)'(signed'({1'b1, {(UW-1){1'b0}}}))) begin
            sum_sat = {1'b1, {(UW-1){1'b0}}};
        end else begin
            sum_sat = sum_w[UW-1:0];
        end
        count_new = count_reg + WW'(in_band_reg);
    end

    // ------------------------------------------ divider request and offset step
    always_comb begin
        sum_mag           = sum_reg[UW-1] ? UW'(-sum_reg) : UW'(sum_reg);
        div_req.start     = (state_reg == S_DLOAD);
        // rounding to nearest: add half the divisor (2 * count)
        div_req.numerator = sum_mag + UW'({count_reg, 1'b0});
        div_req.divisor   = {count_reg, 2'b00};
        off_sum           = sum_neg_reg ? (29'(off_reg) - 29'(quotient))
                                        : (29'(off_reg) + 29'(quotient));
    end

    fefll_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .div_req  (div_req),
        .div_done (div_done),
        .quotient (quotient)
    );

    // ------------------------------------------------------------- sequencer
    assign load_out = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_tvalid) state_next = S_BAND;
            S_BAND:  state_next = (in_lo || in_hi) ? S_MUL : S_ACC;
            S_MUL:   state_next = S_LOOK;
            S_LOOK:  state_next = S_ACC;
            S_ACC:   state_next = (count_new >= window) ? S_DLOAD : S_DONE;
            S_DLOAD: state_next = S_DWAIT;
            S_DWAIT: if (div_done) state_next = S_APPLY;
            S_APPLY: state_next = S_DONE;
            S_DONE:  if (load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            off_reg      <= '0;
            sum_reg      <= '0;
            count_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (state_reg == S_ACC && in_band_reg) begin
                sum_reg   <= sum_sat;
                count_reg <= count_new;
            end
            if (state_reg == S_APPLY) begin
                off_reg   <= fefll_pkg::sat16(off_sum);
                sum_reg   <= '0;
                count_reg <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_tvalid) begin
            x_reg <= s_tdata;
        end
        if (state_reg == S_BAND) begin
            in_band_reg <= in_lo || in_hi;
            d_neg_reg   <= in_lo;
            dmag_reg    <= in_lo ? RW'(lo_w - x_w) : RW'(x_w - hi_w);
            corr_reg    <= fefll_pkg::sat16(29'(x_w - off_w));
        end
        if (state_reg == S_MUL) begin
            prod_reg <= PW'(dmag_reg) * PW'(recip_reg);
        end
        if (state_reg == S_LOOK) begin
            sine_reg <= SINE_TAB[tab_idx];
            // lower half of the turn and the lower band each flip the sign
            sneg_reg <= quad[1] ^ d_neg_reg;
        end
        if (state_reg == S_ACC) begin
            upd_reg <= (count_new >= window);
        end
        if (state_reg == S_DLOAD) begin
            sum_neg_reg <= sum_reg[UW-1];
        end
        if (load_out) begin
            m_tdata_reg <= {7'd0, off_reg, upd_reg, corr_reg};
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

// ===== rtl/core/fefll_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fefll_checker : port checks for the fsk edge frequency locked loop
// watches the stream ports over time, attached to the top level by bind
// ----------------------------------------------------------------------------
module fefll_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire [15:0] s_tdata,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [39:0] m_tdata
);

    // no result word straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    // one word at a time: input closes right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input still ready after accepting a word");

    // a result never appears in the cycle after an accept
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result word too soon after input");

    // stalled result word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // padding above the offset stays zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[39:33] == 7'd0)
        else $error("padding bits set in result word");

endmodule

bind fsk_edge_frequency_locked_loop_unit fefll_checker u_fefll_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench : fsk edge frequency locked loop unit
// streams frequency words through the loop and tracks offset, sine sum and
// band count alongside it; every result word is checked field by field
// ----------------------------------------------------------------------------
module testbench;

    // index with no register behind it, writes must leave the loop untouched
    localparam logic [1:0] REG_SPARE = 2'd3;

    // outer symbol level, +-3.0 in q4.12
    localparam int     LEVEL        = 12288;
    // 28-bit limits of the sine sum
    localparam longint ACC_MAX      = 134217727;
    localparam longint ACC_MIN      = -134217728;
    // wait after the last result, in which a surplus word would still be caught
    localparam int     DRAIN_CYCLES = 48;
    localparam int     PHASES       = 8;
    localparam int     PHASE_WORDS  = 250;

    // offset-driving setup: band 1.0, reciprocal three times too large, so
    // a depth of DRIVE_FAR lands on the -1 peak and DRIVE_NEAR on the +1 peak
    localparam logic [14:0] DRIVE_WIDTH = 15'd4096;
    localparam logic [14:0] DRIVE_RECIP = 15'd12288;
    localparam int          DRIVE_FAR   = 2048;
    localparam int          DRIVE_NEAR  = 683;

    // result word as it sits in m_tdata[32:0], lowest field last
    typedef struct packed {
        logic [15:0] offset;
        logic        updated;
        logic [15:0] corrected;
    } loop_word_t;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_tvalid     = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata      = '0;      // [15:0] freq_sample
    logic        m_tvalid;
    logic        m_tready     = 1'b0;
    logic [39:0] m_tdata;                // [15:0] corrected, [16] updated,
                                         // [32:17] offset, [39:33] zero
    logic        cfg_wr_en    = 1'b0;
    logic [1:0]  cfg_wr_index = '0;
    logic [14:0] cfg_wr_data  = '0;

    // loop state as the block should hold it
    int          quarter_sine [0:fefll_pkg::SINE_DEPTH];
    int          rolloff_q12;
    int          recip_q12;
    int          window_raw;
    int          offset_q12;
    longint      sine_acc;
    int          in_band_count;

    // results still owed by the block, oldest first
    loop_word_t  words_due [$];
    int          fault_count = 0;
    bit          no_idle     = 1'b0;
    int          ready_hold  = 0;

    always #2 aclk = ~aclk;

    fsk_edge_frequency_locked_loop_unit DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    // ------------------------------------------------------------------------
    // arithmetic of the loop
    // ------------------------------------------------------------------------

    function automatic int clamp16(input longint v);
        if (v > 32767) begin
            return 32767;
        end
        if (v < -32768) begin
            return -32768;
        end
        return int'(v);
    endfunction

    // quarter wave in q1.14 from an odd taylor series evaluated in q2.30
    function automatic void build_quarter_sine();
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned term;
        longint          acc;
        for (int i = 0; i <= fefll_pkg::SINE_DEPTH; i++) begin
            ang    = (longint'(1686629713) * i) / fefll_pkg::SINE_DEPTH;
            ang_sq = (ang * ang) >> 30;
            term   = ang;
            acc    = longint'(ang);
            for (int n = 1; n <= 12; n++) begin
                term = ((term * ang_sq) >> 30) / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    acc -= longint'(term);
                end else begin
                    acc += longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            acc = (acc + 32768) >>> 16;
            if (acc > 16384) begin
                acc = 16384;
            end
            quarter_sine[i] = int'(acc);
        end
    endfunction

    // sine of the band depth, phase rounded to a table step, odd in the depth
    function automatic int sine_lookup(input longint d);
        longint unsigned mag;
        longint unsigned phase;
        int              quadrant;
        int              idx;
        int              v;
        mag      = (d < 0) ? -d : d;
        phase    = (mag * recip_q12 * 2 * fefll_pkg::SINE_DEPTH + (64'd1 << 23)) >> 24;
        phase    = phase % (4 * fefll_pkg::SINE_DEPTH);
        quadrant = int'(phase / fefll_pkg::SINE_DEPTH);
        idx      = int'(phase % fefll_pkg::SINE_DEPTH);
        case (quadrant)
            0: v = quarter_sine[idx];
            1: v = quarter_sine[fefll_pkg::SINE_DEPTH - idx];
            2: v = -quarter_sine[idx];
            default: v = -quarter_sine[fefll_pkg::SINE_DEPTH - idx];
        endcase
        return (d < 0) ? -v : v;
    endfunction

    // one accepted sample: band test, sum, window close, result word
    task automatic advance_loop(input logic [15:0] sample);
        longint     x;
        longint     lo;
        longint     hi;
        longint     d;
        longint     div;
        longint     mag;
        longint     step;
        int         window;
        bit         hit;
        loop_word_t w;
        x      = longint'($signed(sample));
        lo     = -LEVEL + offset_q12;
        hi     = LEVEL + offset_q12;
        window = window_raw;
        if (window < 1) begin
            window = 1;
        end
        if (window > fefll_pkg::MAX_WINDOW) begin
            window = fefll_pkg::MAX_WINDOW;
        end
        hit = 1'b0;
        d   = 0;
        if (x < lo && x > lo - rolloff_q12) begin
            hit = 1'b1;
            d   = x - lo;
        end else if (x > hi && x < hi + rolloff_q12) begin
            hit = 1'b1;
            d   = x - hi;
        end
        if (hit) begin
            sine_acc += sine_lookup(d);
            if (sine_acc > ACC_MAX) begin
                sine_acc = ACC_MAX;
            end
            if (sine_acc < ACC_MIN) begin
                sine_acc = ACC_MIN;
            end
            in_band_count++;
        end
        w.corrected = 16'(clamp16(x - offset_q12));
        w.updated   = 1'b0;
        // window closes on count, even when this sample missed the bands
        if (in_band_count >= window) begin
            div  = 4 * longint'(in_band_count);
            mag  = (sine_acc < 0) ? -sine_acc : sine_acc;
            step = (mag + div / 2) / div;
            if (sine_acc < 0) begin
                step = -step;
            end
            offset_q12    = clamp16(offset_q12 + step);
            sine_acc      = 0;
            in_band_count = 0;
            w.updated     = 1'b1;
        end
        w.offset = 16'(offset_q12);
        words_due.push_back(w);
    endtask

    // ------------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------------

    // enable stays high for back-to-back writes; the next send lowers it
    task automatic write_reg(input logic [1:0] idx, input logic [14:0] value);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        @(posedge aclk);
        case (idx)
            fefll_pkg::REG_ROLLOFF_WIDTH:  rolloff_q12 = value;
            fefll_pkg::REG_ROLLOFF_RECIP:  recip_q12   = value;
            fefll_pkg::REG_UPDATE_SAMPLES: window_raw  = value & 15'h1FFF;
            default: ;
        endcase
    endtask

    // one word on the input channel, with a random gap in front
    task automatic send_sample(input logic [15:0] x);
        int gap;
        cfg_wr_en <= 1'b0;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        do @(posedge aclk); while (!s_tready);
        advance_loop(x);
    endtask

    // stop sending and wait until every owed word has come back
    task automatic drain_words();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (words_due.size() != 0);
    endtask

    // sample at a depth beyond the shifted outer level, lower or upper band
    function automatic logic [15:0] band_sample(input bit upper, input longint depth);
        longint x;
        x = upper ? LEVEL + offset_q12 + depth : -LEVEL + offset_q12 - depth;
        return 16'(clamp16(x));
    endfunction

    // sample that moves the offset by a full step under the driving setup;
    // switches band when the preferred one has left the 16-bit range
    function automatic logic [15:0] drive_sample(input bit up);
        longint x;
        if (up) begin
            x = (offset_q12 - LEVEL - DRIVE_FAR >= -32768) ?
                offset_q12 - LEVEL - DRIVE_FAR : offset_q12 + LEVEL + DRIVE_NEAR;
        end else begin
            x = (offset_q12 + LEVEL + DRIVE_FAR <= 32767) ?
                offset_q12 + LEVEL + DRIVE_FAR : offset_q12 - LEVEL - DRIVE_NEAR;
        end
        return 16'(clamp16(x));
    endfunction

    // mostly samples around the bands, the rest anywhere in range
    function automatic logic [15:0] random_sample();
        int     pick;
        longint depth;
        pick  = $urandom_range(0, 99);
        depth = $urandom_range(0, rolloff_q12 + 2);
        if (pick < 40) begin
            return band_sample(1'b0, depth);
        end
        if (pick < 80) begin
            return band_sample(1'b1, depth);
        end
        return 16'($urandom());
    endfunction

    task automatic load_random_setting();
        logic [14:0] width;
        logic [14:0] recip;
        logic [14:0] win;
        int          matched;
        width = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(0, 32767))
                                            : 15'($urandom_range(1024, 8192));
        // reciprocal mostly consistent with the width, sometimes arbitrary
        matched = (width == 0) ? 32767 : (1 << 24) / int'(width);
        if (matched > 32767) begin
            matched = 32767;
        end
        recip = ($urandom_range(0, 9) < 7) ? 15'(matched) : 15'($urandom_range(0, 32767));
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: win = 15'($urandom_range(1, 32));
            7, 8:                win = 15'($urandom_range(33, 300));
            default:             win = 15'($urandom_range(0, 32767));
        endcase
        write_reg(fefll_pkg::REG_ROLLOFF_WIDTH, width);
        write_reg(fefll_pkg::REG_ROLLOFF_RECIP, recip);
        write_reg(fefll_pkg::REG_UPDATE_SAMPLES, win);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // full-scale, zero and minus-one samples at reset settings
    task automatic check_sample_extremes();
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
    endtask

    // bands are open: edges probed on both sides, lower inner one inside only
    task automatic check_band_edges();
        longint r;
        r = rolloff_q12;
        send_sample(band_sample(1'b0, r));
        send_sample(band_sample(1'b0, r - 1));
        send_sample(band_sample(1'b0, 1));
        send_sample(band_sample(1'b1, 0));
        send_sample(band_sample(1'b1, 1));
        send_sample(band_sample(1'b1, r - 1));
        send_sample(band_sample(1'b1, r));
    endtask

    // window below one and above the maximum are clamped
    task automatic check_window_clamp();
        drain_words();
        write_reg(fefll_pkg::REG_UPDATE_SAMPLES, 15'd0);
        send_sample(band_sample(1'b1, rolloff_q12 / 2));
        drain_words();
        // widest band and reciprocal, window write with the top bits set
        write_reg(fefll_pkg::REG_ROLLOFF_WIDTH, 15'h7FFF);
        write_reg(fefll_pkg::REG_ROLLOFF_RECIP, 15'h7FFF);
        write_reg(fefll_pkg::REG_UPDATE_SAMPLES, 15'h7FFF);
        send_sample(band_sample(1'b0, 16000));
        send_sample(band_sample(1'b1, 9000));
        drain_words();
        write_reg(fefll_pkg::REG_UPDATE_SAMPLES, 15'd4096);
        send_sample(band_sample(1'b0, 100));
        drain_words();
        write_reg(fefll_pkg::REG_UPDATE_SAMPLES, 15'd4097);
        send_sample(band_sample(1'b1, 100));
    endtask

    // count already past a newly lowered window closes on the next sample
    task automatic check_window_lowered();
        drain_words();
        write_reg(fefll_pkg::REG_ROLLOFF_WIDTH, 15'd6554);
        write_reg(fefll_pkg::REG_ROLLOFF_RECIP, 15'd2560);
        write_reg(fefll_pkg::REG_UPDATE_SAMPLES, 15'd8);
        repeat (3) begin
            send_sample(band_sample(1'($urandom_range(0, 1)),
                                    $urandom_range(1, rolloff_q12 - 1)));
        end
        drain_words();
        write_reg(fefll_pkg::REG_UPDATE_SAMPLES, 15'd2);
        send_sample(16'h0000);
    endtask

    // zero reciprocal adds nothing, zero or unit width empties the bands
    task automatic check_zero_settings();
        drain_words();
        write_reg(fefll_pkg::REG_ROLLOFF_RECIP, 15'd0);
        write_reg(fefll_pkg::REG_UPDATE_SAMPLES, 15'd1);
        send_sample(band_sample(1'b1, rolloff_q12 / 2));
        drain_words();
        write_reg(fefll_pkg::REG_ROLLOFF_WIDTH, 15'd0);
        write_reg(REG_SPARE, 15'($urandom_range(0, 32767)));
        send_sample(band_sample(1'b1, 1));
        drain_words();
        write_reg(fefll_pkg::REG_ROLLOFF_WIDTH, 15'd1);
        send_sample(band_sample(1'b0, 1));
    endtask

    // random settings per phase, but two phases push the offset, one to each rail
    task automatic run_random_phases();
        for (int p = 0; p < PHASES; p++) begin
            drain_words();
            no_idle = (p % 3 == 2);
            if (p == 2 || p == 5) begin
                write_reg(fefll_pkg::REG_ROLLOFF_WIDTH, DRIVE_WIDTH);
                write_reg(fefll_pkg::REG_ROLLOFF_RECIP, DRIVE_RECIP);
                write_reg(fefll_pkg::REG_UPDATE_SAMPLES, 15'd1);
                repeat (PHASE_WORDS) begin
                    if ($urandom_range(0, 4) == 0) begin
                        send_sample(16'($urandom()));
                    end else begin
                        send_sample(drive_sample(p == 2));
                    end
                end
            end else begin
                load_random_setting();
                repeat (PHASE_WORDS) begin
                    send_sample(random_sample());
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // result side: random back-pressure and field checks
    // ------------------------------------------------------------------------

    task automatic flag_mismatch(input string what, input longint want, input longint got);
        fault_count++;
        $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    endtask

    always @(posedge aclk) begin : word_check
        loop_word_t seen;
        loop_word_t due;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            ready_hold = $urandom_range(0, 15);
        end else begin
            if (m_tvalid && m_tready) begin
                seen = m_tdata[32:0];
                if (words_due.size() == 0) begin
                    fault_count++;
                    $display("%0t unexpected word: expected none, actual %h", $time, m_tdata);
                end else begin
                    due = words_due.pop_front();
                    if (seen.corrected !== due.corrected) begin
                        flag_mismatch("corrected_sample", longint'($signed(due.corrected)),
                                      longint'($signed(seen.corrected)));
                    end
                    if (seen.updated !== due.updated) begin
                        flag_mismatch("offset_updated", due.updated, seen.updated);
                    end
                    if (seen.offset !== due.offset) begin
                        flag_mismatch("offset_value", longint'($signed(due.offset)),
                                      longint'($signed(seen.offset)));
                    end
                    if (m_tdata[39:33] !== '0) begin
                        flag_mismatch("padding", 0, m_tdata[39:33]);
                    end
                end
                ready_hold = no_idle ? 0 : $urandom_range(0, 15);
            end
            if (ready_hold > 0) begin
                m_tready <= 1'b0;
                ready_hold--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial begin
        build_quarter_sine();
        rolloff_q12   = 6554;
        recip_q12     = 2560;
        window_raw    = 256;
        offset_q12    = 0;
        sine_acc      = 0;
        in_band_count = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        check_sample_extremes();
        check_band_edges();
        check_window_clamp();
        check_window_lowered();
        check_zero_settings();
        run_random_phases();

        drain_words();
        // a late surplus word would still be caught here
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0) begin
            $display("[fsk_edge_frequency_locked_loop_unit] OK");
        end else begin
            $display("[fsk_edge_frequency_locked_loop_unit] ERROR");
        end
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial begin
        #3000000;
        $display("[fsk_edge_frequency_locked_loop_unit] ERROR");
        $finish;
    end

endmodule
